### src/pyalu_pkg.sv
// Shared types and codes for the Python-semantics integer ALU.
// Holds the request and response payload structs, opcode and error codes,
// and the sequencer state type. No dependencies.
package pyalu_pkg;

  // Opcodes carried in the request.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_FDIV = 3'd3;
  localparam logic [2:0] OP_MOD  = 3'd4;
  localparam logic [2:0] OP_POW  = 3'd5;

  // Error codes carried in the response.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_NEG_EXP  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } pyalu_req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         error_code;
  } pyalu_rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_DIV_A,
    ST_DIV_B,
    ST_DIV,
    ST_FIX1,
    ST_FIX2,
    ST_PW_CHECK,
    ST_WRITE
  } pyalu_state_t;

endpackage

### src/python_int_alu_core.sv
// Integer ALU with Python semantics: add, subtract, multiply, floor divide,
// modulo and power on DATA_WIDTH-bit signed values, built around one shared adder.
// Depends on pyalu_pkg for payload structs, codes and the state type.
//
// Usage:
//   A request (opcode, operand_a, operand_b) is taken on req_valid && req_ready.
//   Only the low DATA_WIDTH bits of each operand are used. The response
//   (result_value sign-extended to 64 bits, error_code) is offered on rsp_valid
//   and held until rsp_ready. A zero divisor or a negative exponent gives a
//   zero result with a nonzero error code; unused opcodes give zero.
//   The block works on one request at a time; req_ready is high only when the
//   sequencer is idle. The response sits in its own register, so a new
//   request is accepted while an earlier response still waits.
//   req_ready rises again in the same cycle that rsp_valid offers the previous response.
// Work per operation (W = DATA_WIDTH):
//   add, subtract: one pass through the shared adder; error cases and unused
//   opcodes go straight to write-back. multiply: one multiplier bit per cycle.
//   floor divide, modulo: magnitudes of both operands, then one quotient bit
//   per cycle through the shared adder, then the floor fix-up in ST_FIX1;
//   modulo by a negative divisor also passes ST_FIX2. power: one shift-add
//   multiply per set exponent bit plus one squaring per exponent bit below the
//   top one.
// If the receiver stalls, a finished result waits in the sequencer until the
//   response register frees up. Reset clears the sequencer and drops rsp_valid.
module python_int_alu_core #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pyalu_pkg::pyalu_req_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pyalu_pkg::pyalu_rsp_t rsp
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  pyalu_pkg::pyalu_state_t state, state_next;

  logic [2:0]       op, op_next;
  logic             sign_a, sign_a_next;
  logic             sign_b, sign_b_next;
  logic [W-1:0]     base, base_next;
  logic [W-1:0]     expo, expo_next;
  logic [W-1:0]     acc, acc_next;
  logic [W-1:0]     mcand, mcand_next;
  logic [W-1:0]     mplier, mplier_next;
  logic [W-1:0]     prod, prod_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             mul_sq, mul_sq_next;
  logic [1:0]       err, err_next;
  logic             rsp_valid_next;
  pyalu_pkg::pyalu_rsp_t rsp_next;

  logic [W-1:0] a_in;
  logic [W-1:0] b_in;
  logic [W-1:0] div_shift;
  logic [W-1:0] add_x;
  logic [W-1:0] add_y;
  logic         add_c;
  logic [W:0]   sum;
  logic         differ;

  assign req_ready = (state == pyalu_pkg::ST_IDLE);
  assign a_in      = req.operand_a[W-1:0];
  assign b_in      = req.operand_b[W-1:0];
  assign div_shift = {prod[W-2:0], mplier[W-1]};
  assign differ    = sign_a ^ sign_b;

  // Shared adder: operands are selected by the sequencer state.
  always_comb begin
    add_x = '0;
    add_y = '0;
    add_c = 1'b0;
    case (state)
      pyalu_pkg::ST_ADDSUB: begin
        add_x = base;
        add_y = (op == pyalu_pkg::OP_SUB) ? ~expo : expo;
        add_c = (op == pyalu_pkg::OP_SUB);
      end
      pyalu_pkg::ST_DIV_A: begin
        add_y = ~base;
        add_c = 1'b1;
      end
      pyalu_pkg::ST_DIV_B: begin
        add_y = ~expo;
        add_c = 1'b1;
      end
      pyalu_pkg::ST_DIV: begin
        add_x = div_shift;
        add_y = ~mcand;
        add_c = 1'b1;
      end
      pyalu_pkg::ST_MUL: begin
        add_x = prod;
        add_y = mcand;
      end
      pyalu_pkg::ST_FIX1: begin
        if (op == pyalu_pkg::OP_FDIV) begin
          // Negated quotient; one step larger in magnitude when a remainder exists.
          add_y = ~mplier;
          add_c = (prod == '0);
        end else begin
          add_x = mcand;
          add_y = ~prod;
          add_c = 1'b1;
        end
      end
      pyalu_pkg::ST_FIX2: begin
        add_y = ~acc;
        add_c = 1'b1;
      end
      default: begin
      end
    endcase
    sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_c};
  end

  // Sequencer: next state and datapath register updates.
  always_comb begin
    state_next     = state;
    op_next        = op;
    sign_a_next    = sign_a;
    sign_b_next    = sign_b;
    base_next      = base;
    expo_next      = expo;
    acc_next       = acc;
    mcand_next     = mcand;
    mplier_next    = mplier;
    prod_next      = prod;
    cnt_next       = cnt;
    mul_sq_next    = mul_sq;
    err_next       = err;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      pyalu_pkg::ST_IDLE: begin
        if (req_valid) begin
          op_next     = req.opcode;
          base_next   = a_in;
          expo_next   = b_in;
          sign_a_next = a_in[W-1];
          sign_b_next = b_in[W-1];
          err_next    = pyalu_pkg::ERR_NONE;
          acc_next    = '0;
          case (req.opcode)
            pyalu_pkg::OP_ADD, pyalu_pkg::OP_SUB: begin
              state_next = pyalu_pkg::ST_ADDSUB;
            end
            pyalu_pkg::OP_MUL: begin
              mcand_next  = a_in;
              mplier_next = b_in;
              prod_next   = '0;
              state_next  = pyalu_pkg::ST_MUL;
            end
            pyalu_pkg::OP_FDIV, pyalu_pkg::OP_MOD: begin
              if (b_in == '0) begin
                err_next   = pyalu_pkg::ERR_ZERO_DIV;
                state_next = pyalu_pkg::ST_WRITE;
              end else begin
                state_next = pyalu_pkg::ST_DIV_A;
              end
            end
            pyalu_pkg::OP_POW: begin
              if (b_in[W-1]) begin
                err_next   = pyalu_pkg::ERR_NEG_EXP;
                state_next = pyalu_pkg::ST_WRITE;
              end else begin
                acc_next   = W'(1);
                state_next = pyalu_pkg::ST_PW_CHECK;
              end
            end
            default: begin
              state_next = pyalu_pkg::ST_WRITE;
            end
          endcase
        end
      end

      pyalu_pkg::ST_ADDSUB: begin
        acc_next   = sum[W-1:0];
        state_next = pyalu_pkg::ST_WRITE;
      end

      // Take magnitudes of dividend and divisor.
      pyalu_pkg::ST_DIV_A: begin
        mplier_next = sign_a ? sum[W-1:0] : base;
        state_next  = pyalu_pkg::ST_DIV_B;
      end
      pyalu_pkg::ST_DIV_B: begin
        mcand_next = sign_b ? sum[W-1:0] : expo;
        prod_next  = '0;
        cnt_next   = '0;
        state_next = pyalu_pkg::ST_DIV;
      end

      // Restoring divide: one quotient bit per cycle, shifted into mplier.
      pyalu_pkg::ST_DIV: begin
        prod_next   = sum[W] ? sum[W-1:0] : div_shift;
        mplier_next = {mplier[W-2:0], sum[W]};
        cnt_next    = CNT_W'(cnt + 1'b1);
        if (cnt == CNT_W'(W - 1)) begin
          state_next = pyalu_pkg::ST_FIX1;
        end
      end

      // Apply floor rounding, or move the remainder to the divisor's side.
      pyalu_pkg::ST_FIX1: begin
        if (op == pyalu_pkg::OP_FDIV) begin
          acc_next   = differ ? sum[W-1:0] : mplier;
          state_next = pyalu_pkg::ST_WRITE;
        end else begin
          if (prod == '0) begin
            acc_next = '0;
          end else begin
            acc_next = differ ? sum[W-1:0] : prod;
          end
          state_next = sign_b ? pyalu_pkg::ST_FIX2 : pyalu_pkg::ST_WRITE;
        end
      end
      pyalu_pkg::ST_FIX2: begin
        acc_next   = sum[W-1:0];
        state_next = pyalu_pkg::ST_WRITE;
      end

      // Square-and-multiply: pick the next multiply from the low exponent bit.
      pyalu_pkg::ST_PW_CHECK: begin
        if (expo == '0) begin
          state_next = pyalu_pkg::ST_WRITE;
        end else begin
          mcand_next  = base;
          mplier_next = expo[0] ? acc : base;
          mul_sq_next = ~expo[0];
          prod_next   = '0;
          state_next  = pyalu_pkg::ST_MUL;
        end
      end

      // Shift-add multiply, low W bits, ends once the multiplier runs out.
      pyalu_pkg::ST_MUL: begin
        if (mplier == '0) begin
          if (op == pyalu_pkg::OP_MUL) begin
            acc_next   = prod;
            state_next = pyalu_pkg::ST_WRITE;
          end else if (!mul_sq) begin
            acc_next = prod;
            if (expo[W-1:1] == '0) begin
              state_next = pyalu_pkg::ST_WRITE;
            end else begin
              mcand_next  = base;
              mplier_next = base;
              prod_next   = '0;
              mul_sq_next = 1'b1;
            end
          end else begin
            base_next  = prod;
            expo_next  = {1'b0, expo[W-1:1]};
            state_next = pyalu_pkg::ST_PW_CHECK;
          end
        end else begin
          if (mplier[0]) begin
            prod_next = sum[W-1:0];
          end
          mcand_next  = {mcand[W-2:0], 1'b0};
          mplier_next = {1'b0, mplier[W-1:1]};
        end
      end

      // Hand the result to the response register once it is free.
      pyalu_pkg::ST_WRITE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.result_value = 64'($signed(acc));
          rsp_next.error_code   = err;
          rsp_valid_next        = 1'b1;
          state_next            = pyalu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = pyalu_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pyalu_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Datapath and response payload.
  always_ff @(posedge clk) begin
    op     <= op_next;
    sign_a <= sign_a_next;
    sign_b <= sign_b_next;
    base   <= base_next;
    expo   <= expo_next;
    acc    <= acc_next;
    mcand  <= mcand_next;
    mplier <= mplier_next;
    prod   <= prod_next;
    cnt    <= cnt_next;
    mul_sq <= mul_sq_next;
    err    <= err_next;
    rsp    <= rsp_next;
  end

`ifndef SYNTHESIS
  // A zero divisor goes straight to the write-back with the error set.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.operand_b[W-1:0] == '0 &&
    (req.opcode == pyalu_pkg::OP_FDIV || req.opcode == pyalu_pkg::OP_MOD)
    |=> state == pyalu_pkg::ST_WRITE && err == pyalu_pkg::ERR_ZERO_DIV)
    else $error("zero divisor not flagged");

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    state == pyalu_pkg::ST_DIV |-> prod < mcand)
    else $error("partial remainder out of range");

  // An error response always carries a zero result.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != pyalu_pkg::ERR_NONE |-> rsp.result_value == '0)
    else $error("error response with nonzero result");

  // In the cycle after a request is taken, the block is busy.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");
`endif

endmodule

### tb/python_int_alu_core_monitor.sv
// Response checker for the Python-semantics integer ALU: watches both channels,
// predicts each response from the accepted request and compares field by field.
// Depends on pyalu_pkg for the payload structs, opcodes and error codes.
module python_int_alu_core_monitor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  pyalu_pkg::pyalu_req_t req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  pyalu_pkg::pyalu_rsp_t rsp,
  output int                    mismatch_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  pyalu_pkg::pyalu_rsp_t expected_results[$];
  int                    mismatches = 0;
  int                    waiting = 0;

  assign mismatch_count = mismatches;
  assign outstanding = waiting;

  // Python integer arithmetic on 64-bit two's complement values.
  function automatic pyalu_pkg::pyalu_rsp_t python_alu_result(input pyalu_pkg::pyalu_req_t r);
    logic [63:0]           a, b, mag_a, mag_b, quo, rem, mod_mag, acc, base;
    logic                  signs_differ;
    pyalu_pkg::pyalu_rsp_t res;
    a = r.operand_a;
    b = r.operand_b;
    mag_a = a[63] ? 64'd0 - a : a;
    mag_b = b[63] ? 64'd0 - b : b;
    signs_differ = a[63] ^ b[63];
    res.result_value = '0;
    res.error_code = pyalu_pkg::ERR_NONE;
    case (r.opcode)
      pyalu_pkg::OP_ADD: res.result_value = a + b;
      pyalu_pkg::OP_SUB: res.result_value = a - b;
      pyalu_pkg::OP_MUL: res.result_value = a * b;
      pyalu_pkg::OP_FDIV: begin
        if (b == 64'd0) begin
          res.error_code = pyalu_pkg::ERR_ZERO_DIV;
        end else begin
          quo = mag_a / mag_b;
          rem = mag_a % mag_b;
          // Round toward minus infinity when the signs differ.
          if (signs_differ) begin
            if (rem != 64'd0) quo = quo + 64'd1;
            quo = 64'd0 - quo;
          end
          res.result_value = quo;
        end
      end
      pyalu_pkg::OP_MOD: begin
        if (b == 64'd0) begin
          res.error_code = pyalu_pkg::ERR_ZERO_DIV;
        end else begin
          rem = mag_a % mag_b;
          // The remainder follows the sign of the divisor.
          if (rem == 64'd0) mod_mag = '0;
          else if (signs_differ) mod_mag = mag_b - rem;
          else mod_mag = rem;
          res.result_value = b[63] ? 64'd0 - mod_mag : mod_mag;
        end
      end
      pyalu_pkg::OP_POW: begin
        if (b[63]) begin
          res.error_code = pyalu_pkg::ERR_NEG_EXP;
        end else begin
          acc = 64'd1;
          base = a;
          for (int i = 0; i < 64; i++) begin
            if (b[i]) acc = acc * base;
            base = base * base;
          end
          res.result_value = acc;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Queue a prediction per accepted request and check each accepted response.
  always @(posedge clk) begin
    pyalu_pkg::pyalu_rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_results.push_back(python_alu_result(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected response: result_value %h error_code %0d",
                     rsp.result_value, rsp.error_code);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.result_value !== want.result_value || rsp.error_code !== want.error_code) begin
            if (mismatches < REPORT_LIMIT)
              $display("mismatch: result_value exp %h got %h, error_code exp %0d got %0d",
                       want.result_value, rsp.result_value, want.error_code, rsp.error_code);
            mismatches++;
          end
        end
      end
      waiting = expected_results.size();
    end
  end

endmodule

### tb/python_int_alu_core_test.sv
// Top of the testbench for python_int_alu_core: clock, reset, request stimulus,
// response back-pressure and the verdict. Relies on python_int_alu_core_monitor and pyalu_pkg.
module python_int_alu_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  OP_SPARE_LO = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINUS_ONE = '1;
  localparam int          CYCLE_LIMIT = 20_000_000;
  localparam int          HOLD_CYCLES = 600;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  pyalu_pkg::pyalu_req_t req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  pyalu_pkg::pyalu_rsp_t rsp;
  logic                  req_fire = 1'b0;
  bit                    steady = 1'b0;
  bit                    hold_request = 1'b0;
  int                    mismatch_count;
  int                    outstanding;
  int                    cycle_count = 0;

  python_int_alu_core #(.DATA_WIDTH(64)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  python_int_alu_core_monitor result_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Remember whether a request was taken at the last rising edge.
  always @(posedge clk) begin
    req_fire <= req_valid && req_ready;
  end

  // Operand mix: full random, small values, extremes, powers of two, mid widths.
  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = {$urandom, $urandom};
      2: begin
        v = 64'($urandom_range(0, 20));
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MINUS_ONE;
          3: v = '0;
          default: v = 64'd1;
        endcase
      end
      4: begin
        v = 64'd1 << $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v = v - 64'd1;
      end
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(1, 62);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Random request; exponents are mostly short so power stays cheap.
  function automatic pyalu_pkg::pyalu_req_t random_request();
    pyalu_pkg::pyalu_req_t item;
    int                    pick;
    if ($urandom_range(0, 99) < 5)
      item.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    else
      item.opcode = 3'($urandom_range(pyalu_pkg::OP_ADD, pyalu_pkg::OP_POW));
    item.operand_a = random_operand();
    item.operand_b = random_operand();
    pick = $urandom_range(0, 99);
    case (item.opcode)
      pyalu_pkg::OP_FDIV, pyalu_pkg::OP_MOD: begin
        if (pick < 8) begin
          item.operand_b = '0;
        end else if (pick < 13) begin
          item.operand_a = MOST_NEG;
          item.operand_b = MINUS_ONE;
        end
      end
      pyalu_pkg::OP_POW: begin
        if (pick < 12) item.operand_b = {1'b1, 31'($urandom), $urandom};
        else if (pick < 15) item.operand_b = {1'b0, 31'($urandom), $urandom};
        else if (pick < 70) item.operand_b = 64'($urandom_range(0, 64));
        else item.operand_b = 64'($urandom) & ((64'd1 << $urandom_range(1, 12)) - 64'd1);
      end
      default: ;
    endcase
    return item;
  endfunction

  // Offer one request, after a random gap unless in a steady stretch.
  task automatic send_request(input logic [2:0] op, input logic [63:0] a,
                              input logic [63:0] b);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= '{opcode: op, operand_a: a, operand_b: b};
    req_valid <= 1'b1;
    do @(negedge clk); while (!req_fire);
  endtask

  // Stop offering and wait until every predicted response has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    pyalu_pkg::pyalu_req_t item;
    repeat (count) begin
      item = random_request();
      send_request(item.opcode, item.operand_a, item.operand_b);
    end
  endtask

  // Receiver: random stalls, steady stretches, and one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (steady) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("python_int_alu_core_test: errors");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Wrapping add, subtract and multiply at the extremes.
    send_request(pyalu_pkg::OP_ADD, MOST_POS, 64'd1);
    send_request(pyalu_pkg::OP_ADD, MOST_NEG, MINUS_ONE);
    send_request(pyalu_pkg::OP_SUB, MOST_NEG, 64'd1);
    send_request(pyalu_pkg::OP_SUB, 64'd0, MOST_NEG);
    send_request(pyalu_pkg::OP_MUL, MOST_POS, MOST_POS);
    send_request(pyalu_pkg::OP_MUL, MOST_NEG, MINUS_ONE);
    // Floor division in all sign combinations, overflow and zero divisor.
    send_request(pyalu_pkg::OP_FDIV, 64'd7, 64'd2);
    send_request(pyalu_pkg::OP_FDIV, -64'sd7, 64'd2);
    send_request(pyalu_pkg::OP_FDIV, 64'd7, -64'sd2);
    send_request(pyalu_pkg::OP_FDIV, -64'sd7, -64'sd2);
    send_request(pyalu_pkg::OP_FDIV, MOST_NEG, MINUS_ONE);
    send_request(pyalu_pkg::OP_FDIV, MOST_POS, 64'd0);
    // Modulo takes the divisor's sign; also an exact case, overflow and zero divisor.
    send_request(pyalu_pkg::OP_MOD, -64'sd7, 64'd2);
    send_request(pyalu_pkg::OP_MOD, 64'd7, -64'sd2);
    send_request(pyalu_pkg::OP_MOD, -64'sd7, -64'sd2);
    send_request(pyalu_pkg::OP_MOD, 64'd6, 64'd3);
    send_request(pyalu_pkg::OP_MOD, MOST_NEG, MINUS_ONE);
    send_request(pyalu_pkg::OP_MOD, MOST_NEG, 64'd0);
    // Power: zero to the zero, wrap, the longest exponent, a negative one.
    send_request(pyalu_pkg::OP_POW, 64'd0, 64'd0);
    send_request(pyalu_pkg::OP_POW, 64'd2, 64'd63);
    send_request(pyalu_pkg::OP_POW, 64'd3, 64'd40);
    send_request(pyalu_pkg::OP_POW, MINUS_ONE, MOST_POS);
    send_request(pyalu_pkg::OP_POW, 64'd5, MOST_NEG);
    // Unused opcodes.
    send_request(OP_SPARE_LO, MOST_POS, MINUS_ONE);
    send_request(OP_SPARE_HI, MINUS_ONE, MOST_NEG);

    // Let the block go fully idle before the random part.
    drain_results();
    send_random(250);

    // Receiver holds off while requests keep coming, so the block backs up.
    steady = 1'b1;
    hold_request = 1'b1;
    repeat (12) send_request(pyalu_pkg::OP_ADD, random_operand(), random_operand());
    steady = 1'b0;
    drain_results();

    // No idling on either side.
    steady = 1'b1;
    send_random(120);
    steady = 1'b0;

    send_random(250);

    drain_results();
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("python_int_alu_core_test: clean");
    end else begin
      $display("python_int_alu_core_test: errors");
    end
    $finish;
  end

endmodule
